FILE: rtl/hdrp_pkg.sv
// ----------------------------------------------------------------------------
// hdrp_pkg: shared types and constants of the frame header parser
// Word layouts of both channels, status and kind codes, header constants.
// ----------------------------------------------------------------------------
package hdrp_pkg;

  localparam logic [7:0] ETH_HDR_LEN = 8'd14;
  localparam logic [5:0] MIN_HDR_LEN = 6'd20;
  localparam logic [7:0] PROTO_TCP   = 8'd6;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_IP_SHORT  = 3'd1;
  localparam logic [2:0] STATUS_NOT_TCP   = 3'd2;
  localparam logic [2:0] STATUS_TCP_SHORT = 3'd3;
  localparam logic [2:0] STATUS_TRUNC     = 3'd4;

  localparam logic KIND_HDR = 1'b0;
  localparam logic KIND_PAY = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_frame_end;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload_len;
    logic [7:0]  payload_byte;
    logic        packet_done;
  } result_t;

endpackage

FILE: rtl/hdrp_if.sv
// ----------------------------------------------------------------------------
// hdrp_if: channel interfaces of the frame header parser
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hdrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_frame_end;

  modport source (output valid, output in_byte, output in_frame_end, input ready);
  modport sink   (input valid, input in_byte, input in_frame_end, output ready);
endinterface

interface hdrp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  status;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [15:0] payload_len;
  logic [7:0]  payload_byte;
  logic        packet_done;

  modport source (output valid, output kind, output status, output src_addr,
                  output dst_addr, output src_port, output dst_port,
                  output payload_len, output payload_byte, output packet_done,
                  input ready);
  modport sink   (input valid, input kind, input status, input src_addr,
                  input dst_addr, input src_port, input dst_port,
                  input payload_len, input payload_byte, input packet_done,
                  output ready);
endinterface

FILE: rtl/hdrp_in_stage.sv
// ----------------------------------------------------------------------------
// hdrp_in_stage: input register
// Captures one frame word and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module hdrp_in_stage (
  input  logic              clk,
  input  logic              rst,
  hdrp_in_if.sink           frame,
  input  logic              go,
  output logic              word_valid,
  output hdrp_pkg::in_word_t word
);

  logic take;

  assign frame.ready = !word_valid || go;
  assign take        = frame.valid && frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (take) begin
      word_valid <= 1'b1;
    end else if (go) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word.in_byte      <= frame.in_byte;
      word.in_frame_end <= frame.in_frame_end;
    end
  end

endmodule

FILE: rtl/hdrp_parse.sv
// ----------------------------------------------------------------------------
// hdrp_parse: header parse state and per-byte decision logic
// Tracks the frame offset, captures header fields, decides the result.
// ----------------------------------------------------------------------------
module hdrp_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  hdrp_pkg::in_word_t word,
  output logic               has_result,
  output hdrp_pkg::result_t  res
);

  localparam logic [1:0] PH_HDR  = 2'd0;
  localparam logic [1:0] PH_PAY  = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;

  localparam logic [7:0] OFF_TLEN_HI = 8'd16;
  localparam logic [7:0] OFF_TLEN_LO = 8'd17;
  localparam logic [7:0] OFF_PROTO   = 8'd23;
  localparam logic [7:0] OFF_SRC_LO  = 8'd26;
  localparam logic [7:0] OFF_SRC_HI  = 8'd29;
  localparam logic [7:0] OFF_DST_LO  = 8'd30;
  localparam logic [7:0] OFF_DST_HI  = 8'd33;

  localparam logic [7:0] LOC_SPORT_HI = 8'd0;
  localparam logic [7:0] LOC_SPORT_LO = 8'd1;
  localparam logic [7:0] LOC_DPORT_HI = 8'd2;
  localparam logic [7:0] LOC_DPORT_LO = 8'd3;
  localparam logic [7:0] LOC_DOFF     = 8'd12;

  logic [7:0]  byte_offset, byte_offset_next;
  logic [1:0]  phase, phase_next;
  logic [5:0]  ip_hdr_bytes, ip_hdr_bytes_next;
  logic [5:0]  tcp_hdr_bytes, tcp_hdr_bytes_next;
  logic [15:0] ip_total_len, ip_total_len_next;
  logic [31:0] src_reg, src_reg_next;
  logic [31:0] dst_reg, dst_reg_next;
  logic [15:0] sport_reg, sport_reg_next;
  logic [15:0] dport_reg, dport_reg_next;
  logic [15:0] payload_left, payload_left_next;

  logic [7:0]  b;
  logic        last;
  logic [7:0]  tcp_start;
  logic [7:0]  loc;
  logic [6:0]  hdrs;
  logic [15:0] plen;
  logic        reject;
  logic [2:0]  rej_status;
  logic        complete;
  logic        done;
  logic [15:0] pl_dec;

  assign b    = word.in_byte;
  assign last = word.in_frame_end;

  assign tcp_start = hdrp_pkg::ETH_HDR_LEN + {2'b00, ip_hdr_bytes};
  assign loc       = byte_offset - tcp_start;
  assign hdrs      = {1'b0, ip_hdr_bytes} + {1'b0, tcp_hdr_bytes};
  assign plen      = (ip_total_len > {9'd0, hdrs}) ? (ip_total_len - {9'd0, hdrs}) : 16'd0;
  assign pl_dec    = (payload_left != 16'd0) ? (payload_left - 16'd1) : payload_left;

  always_comb begin
    byte_offset_next   = byte_offset;
    phase_next         = phase;
    ip_hdr_bytes_next  = ip_hdr_bytes;
    tcp_hdr_bytes_next = tcp_hdr_bytes;
    ip_total_len_next  = ip_total_len;
    src_reg_next       = src_reg;
    dst_reg_next       = dst_reg;
    sport_reg_next     = sport_reg;
    dport_reg_next     = dport_reg;
    payload_left_next  = payload_left;
    reject             = 1'b0;
    rej_status         = hdrp_pkg::STATUS_OK;
    complete           = 1'b0;
    done               = 1'b0;
    has_result         = 1'b0;

    res.kind         = hdrp_pkg::KIND_HDR;
    res.status       = hdrp_pkg::STATUS_OK;
    res.payload_len  = 16'd0;
    res.payload_byte = 8'd0;
    res.packet_done  = 1'b0;

    unique case (phase)
      PH_HDR: begin
        priority if (byte_offset == hdrp_pkg::ETH_HDR_LEN) begin
          ip_hdr_bytes_next = {b[3:0], 2'b00};
          if ({b[3:0], 2'b00} < hdrp_pkg::MIN_HDR_LEN) begin
            reject     = 1'b1;
            rej_status = hdrp_pkg::STATUS_IP_SHORT;
          end
        end else if (byte_offset == OFF_TLEN_HI) begin
          ip_total_len_next = {b, ip_total_len[7:0]};
        end else if (byte_offset == OFF_TLEN_LO) begin
          ip_total_len_next = {ip_total_len[15:8], b};
        end else if (byte_offset == OFF_PROTO) begin
          if (b != hdrp_pkg::PROTO_TCP) begin
            reject     = 1'b1;
            rej_status = hdrp_pkg::STATUS_NOT_TCP;
          end
        end else if (byte_offset >= OFF_SRC_LO && byte_offset <= OFF_SRC_HI) begin
          src_reg_next = {src_reg[23:0], b};
        end else if (byte_offset >= OFF_DST_LO && byte_offset <= OFF_DST_HI) begin
          dst_reg_next = {dst_reg[23:0], b};
        end else if (ip_hdr_bytes >= hdrp_pkg::MIN_HDR_LEN && byte_offset >= tcp_start) begin
          priority if (loc == LOC_SPORT_HI) begin
            sport_reg_next = {b, sport_reg[7:0]};
          end else if (loc == LOC_SPORT_LO) begin
            sport_reg_next = {sport_reg[15:8], b};
          end else if (loc == LOC_DPORT_HI) begin
            dport_reg_next = {b, dport_reg[7:0]};
          end else if (loc == LOC_DPORT_LO) begin
            dport_reg_next = {dport_reg[15:8], b};
          end else if (loc == LOC_DOFF) begin
            tcp_hdr_bytes_next = {b[7:4], 2'b00};
            if ({b[7:4], 2'b00} < hdrp_pkg::MIN_HDR_LEN) begin
              reject     = 1'b1;
              rej_status = hdrp_pkg::STATUS_TCP_SHORT;
            end
          end else if (tcp_hdr_bytes >= hdrp_pkg::MIN_HDR_LEN &&
                       loc == ({2'b00, tcp_hdr_bytes} - 8'd1)) begin
            complete = 1'b1;
          end else begin
          end
        end else begin
        end

        if (byte_offset != 8'hff) begin
          byte_offset_next = byte_offset + 8'd1;
        end

        priority if (reject) begin
          has_result      = 1'b1;
          res.status      = rej_status;
          res.packet_done = 1'b1;
          phase_next      = PH_SKIP;
        end else if (complete) begin
          done              = last || (plen == 16'd0);
          has_result        = 1'b1;
          res.payload_len   = plen;
          res.packet_done   = done;
          payload_left_next = plen;
          phase_next        = done ? PH_SKIP : PH_PAY;
        end else if (last) begin
          has_result      = 1'b1;
          res.status      = hdrp_pkg::STATUS_TRUNC;
          res.packet_done = 1'b1;
        end else begin
        end
      end
      PH_PAY: begin
        payload_left_next = pl_dec;
        done              = last || (pl_dec == 16'd0);
        has_result        = 1'b1;
        res.kind          = hdrp_pkg::KIND_PAY;
        res.payload_byte  = b;
        res.packet_done   = done;
        if (done) begin
          phase_next = PH_SKIP;
        end
      end
      default: begin
        // discard until frame end
      end
    endcase

    res.src_addr = src_reg_next;
    res.dst_addr = dst_reg_next;
    res.src_port = sport_reg_next;
    res.dst_port = dport_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (go && last)) begin
      byte_offset   <= 8'd0;
      phase         <= PH_HDR;
      ip_hdr_bytes  <= 6'd0;
      tcp_hdr_bytes <= 6'd0;
      ip_total_len  <= 16'd0;
      src_reg       <= 32'd0;
      dst_reg       <= 32'd0;
      sport_reg     <= 16'd0;
      dport_reg     <= 16'd0;
      payload_left  <= 16'd0;
    end else if (go) begin
      byte_offset   <= byte_offset_next;
      phase         <= phase_next;
      ip_hdr_bytes  <= ip_hdr_bytes_next;
      tcp_hdr_bytes <= tcp_hdr_bytes_next;
      ip_total_len  <= ip_total_len_next;
      src_reg       <= src_reg_next;
      dst_reg       <= dst_reg_next;
      sport_reg     <= sport_reg_next;
      dport_reg     <= dport_reg_next;
      payload_left  <= payload_left_next;
    end
  end

endmodule

FILE: rtl/hdrp_out_stage.sv
// ----------------------------------------------------------------------------
// hdrp_out_stage: result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module hdrp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  hdrp_pkg::result_t res,
  output logic              free,
  hdrp_out_if.source        result
);

  logic              res_valid;
  hdrp_pkg::result_t res_q;

  assign free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

  assign result.valid        = res_valid;
  assign result.kind         = res_q.kind;
  assign result.status       = res_q.status;
  assign result.src_addr     = res_q.src_addr;
  assign result.dst_addr     = res_q.dst_addr;
  assign result.src_port     = res_q.src_port;
  assign result.dst_port     = res_q.dst_port;
  assign result.payload_len  = res_q.payload_len;
  assign result.payload_byte = res_q.payload_byte;
  assign result.packet_done  = res_q.packet_done;

endmodule

FILE: rtl/ethernet_ipv4_tcp_header_parser_top.sv
// ----------------------------------------------------------------------------
// ethernet_ipv4_tcp_header_parser_top: Ethernet/IPv4/TCP header parser
// Parses frame bytes, emits a header summary word, then forwards payload.
// ----------------------------------------------------------------------------
// Usage:
//   frame  : one frame byte per word, in_frame_end high on the final byte.
//            The Ethernet header is skipped; IPv4 and TCP fields are captured.
//   result : at most one word per input byte. A summary word (kind 0) comes
//            when the headers complete, on a rejection, or on an early frame
//            end (truncated). After an ok summary each payload byte that the
//            IP total length covers comes as a kind 1 word. packet_done marks
//            the last word of a frame; padding and FCS give no words.
//   Throughput: one byte per cycle while no result word is stalled; the parse of a byte is a
//            single pass of logic between the input and result registers.
//   Path: a byte waits in the input register; its result word goes valid once
//            the result register loads it, and holds there until it is taken.
//   Reset: rst (synchronous) empties both registers and returns the parser
//            to the start of a frame; every frame end does the same for the
//            parse state.
//   Stall: while the result word waits, bytes that cause no result keep
//            flowing; a byte that does cause one holds in the input register.
// ----------------------------------------------------------------------------
module ethernet_ipv4_tcp_header_parser_top (
  input  logic       clk,
  input  logic       rst,
  hdrp_in_if.sink    frame,
  hdrp_out_if.source result
);

  logic               word_valid;
  hdrp_pkg::in_word_t word;
  logic               has_result;
  hdrp_pkg::result_t  res;
  logic               out_free;
  logic               go;
  logic               load;

  // Advance the held byte when its result has room, or when it makes none.
  assign go   = word_valid && (out_free || !has_result);
  assign load = go && has_result;

  hdrp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame),
    .go         (go),
    .word_valid (word_valid),
    .word       (word)
  );

  hdrp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .word       (word),
    .has_result (has_result),
    .res        (res)
  );

  hdrp_out_stage u_out_stage (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .res    (res),
    .free   (out_free),
    .result (result)
  );

endmodule

FILE: rtl/hdrp_checker.sv
// ----------------------------------------------------------------------------
// hdrp_checker: port-level checks of the frame header parser
// Watches the result channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
module hdrp_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        kind,
  input logic [2:0]  status,
  input logic [15:0] payload_len,
  input logic [7:0]  payload_byte,
  input logic        packet_done
);

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(status) &&
      $stable(payload_byte) && $stable(packet_done))
    else $error("result word changed while stalled");

  // Any failing status closes the frame on a summary word.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && status != hdrp_pkg::STATUS_OK |->
      kind == hdrp_pkg::KIND_HDR && packet_done)
    else $error("failing status without summary end");

  // Payload words carry ok status and no length.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == hdrp_pkg::KIND_PAY |->
      status == hdrp_pkg::STATUS_OK && payload_len == 16'd0)
    else $error("payload word with status or length");

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind ethernet_ipv4_tcp_header_parser_top hdrp_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .kind         (result.kind),
  .status       (result.status),
  .payload_len  (result.payload_len),
  .payload_byte (result.payload_byte),
  .packet_done  (result.packet_done)
);
